// ----- rtl/core/jssc_pkg.sv -----
// Shared types and constants for the JSON subset syntax checker.
// Holds byte classes, scanner states and the queue entry format; no dependencies.
`timescale 1ns / 1ps

package jssc_pkg;

  localparam int COUNT_WIDTH   = 16;
  localparam int QUEUE_DEPTH   = 2;
  localparam int BALANCE_WIDTH = 16;

  // Character classes; CL_END is the end-of-text class, never produced from a byte.
  typedef enum logic [4:0] {
    CL_OPEN  = 5'd0,
    CL_QUOTE = 5'd1,
    CL_COLON = 5'd2,
    CL_COMMA = 5'd3,
    CL_DIGIT = 5'd4,
    CL_REST  = 5'd5,
    CL_CLOSE = 5'd6,
    CL_END   = 5'd7,
    CL_T     = 5'd8,
    CL_R     = 5'd9,
    CL_U     = 5'd10,
    CL_E     = 5'd11,
    CL_F     = 5'd12,
    CL_A     = 5'd13,
    CL_L     = 5'd14,
    CL_S     = 5'd15,
    CL_N     = 5'd16
  } cls_e;

  typedef enum logic [4:0] {
    S_START   = 5'd0,
    S_OPEN    = 5'd1,
    S_NAME    = 5'd2,
    S_NAMED   = 5'd3,
    S_COLON   = 5'd4,
    S_STR     = 5'd5,
    S_VALDONE = 5'd6,
    S_NUM     = 5'd7,
    S_COMMA   = 5'd8,
    S_CLOSED  = 5'd9,
    S_T       = 5'd10,
    S_TR      = 5'd11,
    S_TRU     = 5'd12,
    S_F       = 5'd13,
    S_FA      = 5'd14,
    S_FAL     = 5'd15,
    S_FALS    = 5'd16,
    S_N       = 5'd17,
    S_NU      = 5'd18,
    S_NUL     = 5'd19,
    S_ERR     = 5'd20,
    S_ACC     = 5'd21
  } st_e;

  typedef struct packed {
    logic is_end;
    cls_e cls;
  } entry_t;

endpackage

// ----- rtl/core/json_subset_syntax_checker_unit.sv -----
// An accepted end beat is queued, then its verdict is registered for out_valid_o.
// Throughput: one beat per cycle while not stalled; the back end does one table
// step and one saturating counter update per beat; the queue absorbs output stalls.
// Reset (rst_ni, async, active low): scanner to start state, brace count to zero,
// queue empty, no result pending. No clearing pass; items are taken right away.
`timescale 1ns / 1ps

module json_subset_syntax_checker_unit #(
  parameter int COUNT_WIDTH = jssc_pkg::COUNT_WIDTH,
  parameter int QUEUE_DEPTH = jssc_pkg::QUEUE_DEPTH
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  // input channel
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      mode_i,
  input  logic [7:0]                                text_byte_i,
  // result channel
  output logic                                      out_valid_o,
  input  logic                                      out_stall_i,
  output logic                                      well_formed_o,
  output logic                                      error_seen_o,
  output logic signed [jssc_pkg::BALANCE_WIDTH-1:0] brace_balance_o
);

  // Front -> queue: one classified beat per accepted input.
  logic             push;
  jssc_pkg::entry_t push_entry;
  logic             q_full;

  // Queue -> back: head beat and the pop strobe.
  logic             q_valid;
  jssc_pkg::entry_t q_entry;
  logic             pop;

  // Accept and classify; stall only when the queue is full.
  jssc_front u_front (
    .in_valid_i   (in_valid_i),
    .mode_i       (mode_i),
    .text_byte_i  (text_byte_i),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .push_entry_o (push_entry),
    .full_i       (q_full)
  );

  // Decouple the front from result back-pressure.
  jssc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .valid_o      (q_valid),
    .entry_o      (q_entry),
    .pop_i        (pop)
  );

  // Advance the scanner, count braces, hold the verdict until taken.
  jssc_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .well_formed_o   (well_formed_o),
    .error_seen_o    (error_seen_o),
    .brace_balance_o (brace_balance_o)
  );

endmodule

// ----- rtl/core/jssc_front.sv -----
// Front end of the JSON subset syntax checker: input handshake and byte classing.
// Depends on jssc_pkg; feeds jssc_queue.
`timescale 1ns / 1ps

module jssc_front (
  input  logic              in_valid_i,
  input  logic              mode_i,
  input  logic [7:0]        text_byte_i,
  output logic              in_stall_o,
  output logic              push_o,
  output jssc_pkg::entry_t  push_entry_o,
  input  logic              full_i
);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_N      = 8'h6E;

  function automatic jssc_pkg::cls_e classify(input logic [7:0] c);
    jssc_pkg::cls_e cls;
    cls = jssc_pkg::CL_REST;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      cls = jssc_pkg::CL_DIGIT;
    end else begin
      unique case (c)
        CH_LBRACE: cls = jssc_pkg::CL_OPEN;
        CH_QUOTE:  cls = jssc_pkg::CL_QUOTE;
        CH_COLON:  cls = jssc_pkg::CL_COLON;
        CH_COMMA:  cls = jssc_pkg::CL_COMMA;
        CH_RBRACE: cls = jssc_pkg::CL_CLOSE;
        CH_T:      cls = jssc_pkg::CL_T;
        CH_R:      cls = jssc_pkg::CL_R;
        CH_U:      cls = jssc_pkg::CL_U;
        CH_E:      cls = jssc_pkg::CL_E;
        CH_F:      cls = jssc_pkg::CL_F;
        CH_A:      cls = jssc_pkg::CL_A;
        CH_L:      cls = jssc_pkg::CL_L;
        CH_S:      cls = jssc_pkg::CL_S;
        CH_N:      cls = jssc_pkg::CL_N;
        default:   cls = jssc_pkg::CL_REST;
      endcase
    end
    return cls;
  endfunction

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_entry_o.is_end = mode_i;
    push_entry_o.cls    = mode_i ? jssc_pkg::CL_END : classify(text_byte_i);
  end

endmodule

// ----- rtl/core/jssc_queue.sv -----
// Small FIFO of classified beats between front and back of the syntax checker.
// Depends on jssc_pkg for the entry format.
`timescale 1ns / 1ps

module jssc_queue #(
  parameter int DEPTH = jssc_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  jssc_pkg::entry_t  push_entry_i,
  output logic              full_o,
  output logic              valid_o,
  output jssc_pkg::entry_t  entry_o,
  input  logic              pop_i
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  jssc_pkg::entry_t entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign entry_o = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_ONE;
      2'b01:   cnt_d = cnt_q - CNT_ONE;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- rtl/core/jssc_back.sv -----
// Back end of the syntax checker: transition table, brace counter, result register.
// Depends on jssc_pkg; drains jssc_queue.
`timescale 1ns / 1ps

module jssc_back #(
  parameter int COUNT_WIDTH = jssc_pkg::COUNT_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   q_valid_i,
  input  jssc_pkg::entry_t                       q_entry_i,
  output logic                                   pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   well_formed_o,
  output logic                                   error_seen_o,
  output logic signed [jssc_pkg::BALANCE_WIDTH-1:0] brace_balance_o
);

  localparam int BW = jssc_pkg::BALANCE_WIDTH;
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
  localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  function automatic jssc_pkg::st_e next_state(input jssc_pkg::st_e st,
                                               input jssc_pkg::cls_e cls);
    jssc_pkg::st_e nx;
    nx = jssc_pkg::S_ERR;
    unique case (st)
      jssc_pkg::S_START: if (cls == jssc_pkg::CL_OPEN) nx = jssc_pkg::S_OPEN;
      jssc_pkg::S_OPEN: begin
        if (cls == jssc_pkg::CL_QUOTE) nx = jssc_pkg::S_NAME;
        else if (cls == jssc_pkg::CL_CLOSE) nx = jssc_pkg::S_CLOSED;
      end
      jssc_pkg::S_NAME: begin
        if (cls == jssc_pkg::CL_QUOTE) nx = jssc_pkg::S_NAMED;
        else if (cls != jssc_pkg::CL_END) nx = jssc_pkg::S_NAME;
      end
      jssc_pkg::S_NAMED: if (cls == jssc_pkg::CL_COLON) nx = jssc_pkg::S_COLON;
      jssc_pkg::S_COLON: begin
        unique case (cls)
          jssc_pkg::CL_OPEN:  nx = jssc_pkg::S_OPEN;
          jssc_pkg::CL_QUOTE: nx = jssc_pkg::S_STR;
          jssc_pkg::CL_DIGIT: nx = jssc_pkg::S_NUM;
          jssc_pkg::CL_T:     nx = jssc_pkg::S_T;
          jssc_pkg::CL_F:     nx = jssc_pkg::S_F;
          jssc_pkg::CL_N:     nx = jssc_pkg::S_N;
          default:            nx = jssc_pkg::S_ERR;
        endcase
      end
      jssc_pkg::S_STR: begin
        if (cls == jssc_pkg::CL_QUOTE) nx = jssc_pkg::S_VALDONE;
        else if (cls != jssc_pkg::CL_END) nx = jssc_pkg::S_STR;
      end
      jssc_pkg::S_VALDONE: begin
        if (cls == jssc_pkg::CL_COMMA) nx = jssc_pkg::S_COMMA;
        else if (cls == jssc_pkg::CL_CLOSE) nx = jssc_pkg::S_CLOSED;
      end
      jssc_pkg::S_NUM: begin
        if (cls == jssc_pkg::CL_COMMA) nx = jssc_pkg::S_COMMA;
        else if (cls == jssc_pkg::CL_DIGIT) nx = jssc_pkg::S_NUM;
        else if (cls == jssc_pkg::CL_CLOSE) nx = jssc_pkg::S_CLOSED;
      end
      jssc_pkg::S_COMMA: if (cls == jssc_pkg::CL_QUOTE) nx = jssc_pkg::S_NAME;
      jssc_pkg::S_CLOSED: begin
        if (cls == jssc_pkg::CL_COMMA) nx = jssc_pkg::S_COMMA;
        else if (cls == jssc_pkg::CL_CLOSE) nx = jssc_pkg::S_CLOSED;
        else if (cls == jssc_pkg::CL_END) nx = jssc_pkg::S_ACC;
      end
      jssc_pkg::S_T:    if (cls == jssc_pkg::CL_R) nx = jssc_pkg::S_TR;
      jssc_pkg::S_TR:   if (cls == jssc_pkg::CL_U) nx = jssc_pkg::S_TRU;
      jssc_pkg::S_TRU:  if (cls == jssc_pkg::CL_E) nx = jssc_pkg::S_VALDONE;
      jssc_pkg::S_F:    if (cls == jssc_pkg::CL_A) nx = jssc_pkg::S_FA;
      jssc_pkg::S_FA:   if (cls == jssc_pkg::CL_L) nx = jssc_pkg::S_FAL;
      jssc_pkg::S_FAL:  if (cls == jssc_pkg::CL_S) nx = jssc_pkg::S_FALS;
      jssc_pkg::S_FALS: if (cls == jssc_pkg::CL_E) nx = jssc_pkg::S_VALDONE;
      jssc_pkg::S_N:    if (cls == jssc_pkg::CL_U) nx = jssc_pkg::S_NU;
      jssc_pkg::S_NU:   if (cls == jssc_pkg::CL_L) nx = jssc_pkg::S_NUL;
      jssc_pkg::S_NUL:  if (cls == jssc_pkg::CL_L) nx = jssc_pkg::S_VALDONE;
      default:          nx = jssc_pkg::S_ERR;
    endcase
    return nx;
  endfunction

  jssc_pkg::st_e                  state_q, state_d;
  logic signed [COUNT_WIDTH-1:0]  count_q, count_d;
  logic                           out_valid_q;
  logic                           well_formed_q, error_q;
  logic signed [BW-1:0]           balance_q;
  logic                           verdict_ok, verdict_err;
  logic signed [BW-1:0]           balance_now;
  logic                           take_end;

  // Only end beats need the result register; text beats always drain.
  assign pop_o    = q_valid_i && (!q_entry_i.is_end || !out_valid_q || !out_stall_i);
  assign take_end = pop_o && q_entry_i.is_end;

  // Next state and count.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    priority if (take_end) begin
      state_d = jssc_pkg::S_START;
      count_d = '0;
    end else if (pop_o && state_q != jssc_pkg::S_ERR) begin
      state_d = next_state(state_q, q_entry_i.cls);
      if (q_entry_i.cls == jssc_pkg::CL_OPEN && count_q != CNT_MAX) begin
        count_d = count_q + CNT_ONE;
      end else if (q_entry_i.cls == jssc_pkg::CL_CLOSE && count_q != CNT_MIN) begin
        count_d = count_q - CNT_ONE;
      end
    end else begin
      state_d = state_q;
      count_d = count_q;
    end
  end

  generate
    if (COUNT_WIDTH >= BW) begin : g_bal_trunc
      assign balance_now = count_q[BW-1:0];
    end else begin : g_bal_sext
      assign balance_now = {{(BW-COUNT_WIDTH){count_q[COUNT_WIDTH-1]}}, count_q};
    end
  endgenerate

  // Verdict outputs.
  always_comb begin
    verdict_err = (state_q == jssc_pkg::S_ERR);
    verdict_ok  = !verdict_err && (count_q == '0) &&
                  (next_state(state_q, jssc_pkg::CL_END) == jssc_pkg::S_ACC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jssc_pkg::S_START;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (take_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_end) begin
      well_formed_q <= verdict_ok;
      error_q       <= verdict_err;
      balance_q     <= balance_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign well_formed_o   = well_formed_q;
  assign error_seen_o    = error_q;
  assign brace_balance_o = balance_q;

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_end |=> (state_q == jssc_pkg::S_START && count_q == '0))
    else $error("scanner not cleared after end beat");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == jssc_pkg::S_ERR && !take_end) |=>
      (state_q == jssc_pkg::S_ERR && $stable(count_q)))
    else $error("error state left or count moved without end beat");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_end |-> (!out_valid_q || !out_stall_i))
    else $error("pending result overwritten");

  a_wf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && well_formed_q) |-> (!error_q && balance_q == '0))
    else $error("well-formed verdict with error or unbalanced braces");
`endif

endmodule
